/* sv/fcull_pkg.sv */
`default_nettype none
package fcull_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_W    = 24;
  localparam int NORM_W     = 12;
  localparam int OFF_W      = 28;
  localparam int FRAC_SHIFT = 10;
  localparam int PROD_W     = NORM_W + COORD_W;
  localparam int DIST_W     = 40;

  // plane register field positions
  localparam int NX_LSB = 52;
  localparam int NY_LSB = 40;
  localparam int NZ_LSB = 28;

  // 0.1 in q16.8
  localparam logic [COORD_W-1:0] RAD_DEFAULT = COORD_W'(26);

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // request traveling down the row of plane cells
  typedef struct packed {
    logic                      valid;
    logic                      box;
    logic                      pass;
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] y_lo;
    logic signed [COORD_W-1:0] z_lo;
    logic signed [COORD_W-1:0] x_hi;
    logic signed [COORD_W-1:0] y_hi;
    logic signed [COORD_W-1:0] z_hi;
    logic        [COORD_W-1:0] rad;
  } item_t;

endpackage
`default_nettype wire

/* sv/fcull_cell.sv */
`default_nettype none
module fcull_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                plane_we,
  input  wire logic [fcull_pkg::PLANE_W-1:0]       plane_data,
  input  wire fcull_pkg::item_t                    item_in,
  output fcull_pkg::item_t                         item_out
);

  logic [fcull_pkg::PLANE_W-1:0] plane_r;

  logic signed [fcull_pkg::NORM_W-1:0]  nx, ny, nz;
  logic signed [fcull_pkg::COORD_W-1:0] px, py, pz;
  logic signed [fcull_pkg::PROD_W-1:0]  prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [fcull_pkg::PROD_W-1:0]  prod_x_r, prod_y_r, prod_z_r;
  fcull_pkg::item_t                     item_a_r;
  fcull_pkg::item_t                     item_b_nxt, item_b_r;
  logic signed [fcull_pkg::DIST_W-1:0]  off_s, rad_s, dist_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (plane_we) begin
      plane_r <= plane_data;
    end
  end

  assign nx = plane_r[fcull_pkg::NX_LSB +: fcull_pkg::NORM_W];
  assign ny = plane_r[fcull_pkg::NY_LSB +: fcull_pkg::NORM_W];
  assign nz = plane_r[fcull_pkg::NZ_LSB +: fcull_pkg::NORM_W];

  // box: take the corner along the normal
  always_comb begin
    px = (item_in.box && !nx[fcull_pkg::NORM_W-1]) ? item_in.x_hi : item_in.x_lo;
    py = (item_in.box && !ny[fcull_pkg::NORM_W-1]) ? item_in.y_hi : item_in.y_lo;
    pz = (item_in.box && !nz[fcull_pkg::NORM_W-1]) ? item_in.z_hi : item_in.z_lo;
    prod_x_nxt = fcull_pkg::PROD_W'(nx) * fcull_pkg::PROD_W'(px);
    prod_y_nxt = fcull_pkg::PROD_W'(ny) * fcull_pkg::PROD_W'(py);
    prod_z_nxt = fcull_pkg::PROD_W'(nz) * fcull_pkg::PROD_W'(pz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_a_r.valid <= 1'b0;
    end else begin
      item_a_r.valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_a_r.box  <= item_in.box;
    item_a_r.pass <= item_in.pass;
    item_a_r.x_lo <= item_in.x_lo;
    item_a_r.y_lo <= item_in.y_lo;
    item_a_r.z_lo <= item_in.z_lo;
    item_a_r.x_hi <= item_in.x_hi;
    item_a_r.y_hi <= item_in.y_hi;
    item_a_r.z_hi <= item_in.z_hi;
    item_a_r.rad  <= item_in.rad;
    prod_x_r      <= prod_x_nxt;
    prod_y_r      <= prod_y_nxt;
    prod_z_r      <= prod_z_nxt;
  end

  // distance plus radius, fails when negative
  always_comb begin
    off_s = {{(fcull_pkg::DIST_W - fcull_pkg::OFF_W - fcull_pkg::FRAC_SHIFT)
              {plane_r[fcull_pkg::OFF_W-1]}},
             plane_r[fcull_pkg::OFF_W-1:0], {fcull_pkg::FRAC_SHIFT{1'b0}}};
    rad_s = {{(fcull_pkg::DIST_W - fcull_pkg::COORD_W - fcull_pkg::FRAC_SHIFT){1'b0}},
             item_a_r.rad, {fcull_pkg::FRAC_SHIFT{1'b0}}};
    dist_sum = fcull_pkg::DIST_W'(prod_x_r) + fcull_pkg::DIST_W'(prod_y_r)
             + fcull_pkg::DIST_W'(prod_z_r) + off_s + rad_s;
    item_b_nxt      = item_a_r;
    item_b_nxt.pass = item_a_r.pass & ~dist_sum[fcull_pkg::DIST_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_b_r.valid <= 1'b0;
    end else begin
      item_b_r.valid <= item_b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_b_r.box  <= item_b_nxt.box;
    item_b_r.pass <= item_b_nxt.pass;
    item_b_r.x_lo <= item_b_nxt.x_lo;
    item_b_r.y_lo <= item_b_nxt.y_lo;
    item_b_r.z_lo <= item_b_nxt.z_lo;
    item_b_r.x_hi <= item_b_nxt.x_hi;
    item_b_r.y_hi <= item_b_nxt.y_hi;
    item_b_r.z_hi <= item_b_nxt.z_hi;
    item_b_r.rad  <= item_b_nxt.rad;
  end

  assign item_out = item_b_r;

endmodule
`default_nettype wire

/* sv/frustum_cull_test.sv */
// frustum culling test: one point, sphere or box against six planes
// the request passes through the a and b registers of each plane cell in turn before the result strobe
// throughput: one request per clock, busy is never raised
// the receiver cannot stall, so out_valid is a one-cycle strobe
// reset (rst_n low, synchronous) clears all plane registers and in-flight requests
`default_nettype none
module frustum_cull_test (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            in_command,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_x_lo,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_y_lo,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_z_lo,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_x_hi,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_y_hi,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_z_hi,
  input  wire logic signed [fcull_pkg::COORD_W-1:0]  in_sphere_radius,
  // result channel
  output logic                                       out_valid,
  output logic                                       out_inside_res,
  // plane register write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [fcull_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [fcull_pkg::PLANE_W-1:0]         cfg_data
);

  fcull_pkg::item_t chain [fcull_pkg::NUM_PLANES+1];
  fcull_pkg::item_t entry;

  // fully pipelined row of cells, nothing ever holds the front off
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // entry stage: classify the command and fix up the radius
  //  - point and box compare against zero, so the radius term is zero
  //  - sphere with a nonpositive radius uses the default of 0.1
  //  - the unused command starts out failed and stays failed
  always_comb begin
    entry       = '0;
    entry.valid = start & ~busy;
    entry.box   = (in_command == fcull_pkg::CMD_BOX);
    entry.pass  = (in_command != fcull_pkg::CMD_NONE);
    entry.x_lo  = in_x_lo;
    entry.y_lo  = in_y_lo;
    entry.z_lo  = in_z_lo;
    entry.x_hi  = in_x_hi;
    entry.y_hi  = in_y_hi;
    entry.z_hi  = in_z_hi;
    if (in_command == fcull_pkg::CMD_SPHERE) begin
      if (in_sphere_radius[fcull_pkg::COORD_W-1] || in_sphere_radius == '0) begin
        entry.rad = fcull_pkg::RAD_DEFAULT;
      end else begin
        entry.rad = in_sphere_radius;
      end
    end
  end

  assign chain[0] = entry;

  // one cell per plane; each owns its plane register and ands its verdict
  // into the pass flag as the request moves down the row
  for (genvar g = 0; g < fcull_pkg::NUM_PLANES; g++) begin : g_cell
    logic we;
    // writes to an index past the last plane match no cell and are dropped
    assign we = cfg_valid & cfg_ready & (int'(cfg_index) == g);

    fcull_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .plane_we   (we),
      .plane_data (cfg_data),
      .item_in    (chain[g]),
      .item_out   (chain[g+1])
    );
  end

  // last cell output is already registered, drive the result straight out
  assign out_valid      = chain[fcull_pkg::NUM_PLANES].valid;
  assign out_inside_res = chain[fcull_pkg::NUM_PLANES].pass;

endmodule
`default_nettype wire
